/* rtl/core/sbr_pkg.sv */
// ============================================================================
// sbr_pkg
// Shared types and constants of the stream byte reassembler.
// ============================================================================
package sbr_pkg;

  // Fixed field widths of the transaction payloads
  localparam int IDX_W   = 64;
  localparam int WIN_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 13;

  // Default buffer depth and register reset value
  localparam int              DEF_DEPTH  = 4096;
  localparam logic [WIN_W-1:0] WIN_RESET = 13'd4096;

  // Operation codes; the remaining code is a no-op
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  stream_index;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic [IDX_W-1:0]  assembled_index;
    logic [CNT_W-1:0]  pending_bytes;
    logic              stream_closed;
  } out_item_t;

  // One buffer entry: held flag and byte
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } slot_t;

endpackage

/* rtl/core/stream_byte_reassembler.sv */
// ============================================================================
// stream_byte_reassembler
// Reassembles an in-order byte stream from out-of-order, overlapping bytes.
//
// Each input transaction writes one byte at an absolute stream index, reads
// the next in-order byte, or declares the end index, and returns exactly one
// result transaction with the read byte, the assembled index, the pending
// count and the closed flag. Bytes and their held flags live in one
// BUFFER_DEPTH x 9 synchronous RAM (slot = index mod BUFFER_DEPTH). An item
// is accepted and the RAM read in ST_IDLE, then checked and written back in
// ST_EXEC. A write that lands on the assembled index then walks the RAM one
// entry per cycle over every byte that joins the contiguous prefix; each
// byte is walked only once. After reset the block clears the whole RAM and
// holds in_stall_o high meanwhile; window_size writes are taken at any time.
// A result not yet taken holds the block after it finishes the next item.
// ============================================================================
module stream_byte_reassembler
  import sbr_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = AW + 1;
  localparam int MW = (CW > WIN_W) ? CW : WIN_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(BUFFER_DEPTH);

  // Advance a slot index with wrap at the buffer depth
  function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
    inc_slot = (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;

  logic [1:0]       act_q, act_d;
  logic [7:0]       wbyte_q, wbyte_d;
  logic [CW-1:0]    off_low_q, off_low_d;
  logic             off_big_q, off_big_d;
  logic [AW-1:0]    wslot_q, wslot_d;

  logic [IDX_W-1:0] rp_q, rp_d;
  logic [IDX_W-1:0] ap_q, ap_d;
  logic [AW-1:0]    rp_slot_q, rp_slot_d;
  logic [AW-1:0]    ap_slot_q, ap_slot_d;
  logic [CW-1:0]    unread_q, unread_d;
  logic [CW-1:0]    pending_q, pending_d;
  logic [CW-1:0]    end_off_q, end_off_d;
  logic             end_known_q, end_known_d;
  logic [WIN_W-1:0] window_q;
  logic [7:0]       rd_q, rd_d;
  logic             rv_q, rv_d;

  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  slot_t            mem [BUFFER_DEPTH];
  slot_t            rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  slot_t            mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             go_scan;
  logic             scan_adv;
  logic             closed_d;

  logic [IDX_W-1:0] off_full;
  logic [CW-1:0]    slot_sum;
  logic [AW-1:0]    in_slot;
  logic [CW-1:0]    cap;
  logic             in_win;
  logic             past_end;
  logic             wr_ok;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LAST_SLOT) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (go_scan)       state_d = ST_SCAN;
        else if (out_free) state_d = ST_IDLE;
        else               state_d = ST_HOLD;
      end
      ST_SCAN: begin
        if (scan_adv)      state_d = ST_SCAN;
        else if (out_free) state_d = ST_IDLE;
        else               state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_EXEC: out_load = !go_scan && out_free;
      ST_SCAN: out_load = !scan_adv && out_free;
      ST_HOLD: out_load = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Slot and window arithmetic
  // --------------------------------------------------------------------------
  // Offset from the read pointer; the slot is only meaningful inside the
  // window, where the offset is below the buffer depth.
  always_comb begin
    off_full = in_item_i.stream_index - rp_q;
    slot_sum = {1'b0, rp_slot_q} + {1'b0, off_full[AW-1:0]};
    if (slot_sum >= DEPTH_C) in_slot = AW'(slot_sum - DEPTH_C);
    else                     in_slot = slot_sum[AW-1:0];
  end

  // Clamp the window to the buffer depth
  always_comb begin
    if (MW'(window_q) > MW'(BUFFER_DEPTH)) cap = DEPTH_C;
    else                                   cap = CW'(window_q);
  end

  assign in_win   = !off_big_q && (off_low_q >= unread_q) && (off_low_q < cap);
  assign past_end = end_known_q && (off_big_q || (off_low_q >= end_off_q));
  assign wr_ok    = (act_q == ACT_WRITE) && in_win && !past_end && !rdata_q.vld;

  // --------------------------------------------------------------------------
  // Datapath: pointers, counters and buffer access
  // --------------------------------------------------------------------------
  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    act_d       = act_q;
    wbyte_d     = wbyte_q;
    off_low_d   = off_low_q;
    off_big_d   = off_big_q;
    wslot_d     = wslot_q;
    rp_d        = rp_q;
    ap_d        = ap_q;
    rp_slot_d   = rp_slot_q;
    ap_slot_d   = ap_slot_q;
    unread_d    = unread_q;
    pending_d   = pending_q;
    end_off_d   = end_off_q;
    end_known_d = end_known_q;
    rd_d        = rd_q;
    rv_d        = rv_q;
    go_scan     = 1'b0;
    scan_adv    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wslot_q;
    mem_wdata   = '0;
    mem_raddr   = ap_slot_q;

    case (state_q)
      // Sweep the buffer and drop every held flag
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end

      // Latch the transaction and look up its slot
      ST_IDLE: begin
        if (accept) begin
          act_d     = in_item_i.action;
          wbyte_d   = in_item_i.data_byte;
          off_low_d = off_full[CW-1:0];
          off_big_d = |off_full[IDX_W-1:CW];
          wslot_d   = in_slot;
        end
        mem_raddr = (in_item_i.action == ACT_READ) ? rp_slot_q : in_slot;
      end

      // Check and write back
      ST_EXEC: begin
        rd_d = '0;
        rv_d = 1'b0;
        case (act_q)
          ACT_WRITE: begin
            if (wr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = wslot_q;
              mem_wdata = '{vld: 1'b1, data: wbyte_q};
              if (off_low_q == unread_q) begin
                // byte joins the prefix; walk on from the next slot
                ap_d      = ap_q + IDX_W'(1);
                ap_slot_d = inc_slot(ap_slot_q);
                unread_d  = unread_q + CW'(1);
                go_scan   = 1'b1;
              end else begin
                pending_d = pending_q + CW'(1);
              end
            end
          end
          ACT_READ: begin
            if (unread_q != '0) begin
              rd_d      = rdata_q.data;
              rv_d      = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = rp_slot_q;
              mem_wdata = '{vld: 1'b0, data: rdata_q.data};
              rp_d      = rp_q + IDX_W'(1);
              rp_slot_d = inc_slot(rp_slot_q);
              unread_d  = unread_q - CW'(1);
              if (end_known_q) end_off_d = end_off_q - CW'(1);
            end
          end
          ACT_END: begin
            if (!end_known_q && !off_big_q && (off_low_q >= unread_q) &&
                (off_low_q <= cap)) begin
              end_known_d = 1'b1;
              end_off_d   = off_low_q;
            end
          end
          default: begin
            rv_d = 1'b0;
          end
        endcase
        mem_raddr = ap_slot_d;
      end

      // Advance the assembled pointer over held bytes, one per cycle
      ST_SCAN: begin
        scan_adv = !(end_known_q && (unread_q == end_off_q)) &&
                   (unread_q != DEPTH_C) && rdata_q.vld;
        if (scan_adv) begin
          ap_d      = ap_q + IDX_W'(1);
          ap_slot_d = inc_slot(ap_slot_q);
          unread_d  = unread_q + CW'(1);
          if (pending_q != '0) pending_d = pending_q - CW'(1);
        end
        mem_raddr = ap_slot_d;
      end

      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign closed_d = end_known_d && (unread_d == end_off_d);

  always_comb begin
    out_item_d = out_item_q;
    if (out_load) begin
      out_item_d.read_data       = rd_d;
      out_item_d.read_valid      = rv_d;
      out_item_d.assembled_index = ap_d;
      out_item_d.pending_bytes   = CNT_W'(pending_d);
      out_item_d.stream_closed   = closed_d;
    end
    if (out_load)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rp_q        <= '0;
      ap_q        <= '0;
      rp_slot_q   <= '0;
      ap_slot_q   <= '0;
      unread_q    <= '0;
      pending_q   <= '0;
      end_off_q   <= '0;
      end_known_q <= 1'b0;
      window_q    <= WIN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rp_q        <= rp_d;
      ap_q        <= ap_d;
      rp_slot_q   <= rp_slot_d;
      ap_slot_q   <= ap_slot_d;
      unread_q    <= unread_d;
      pending_q   <= pending_d;
      end_off_q   <= end_off_d;
      end_known_q <= end_known_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold the current transaction and result
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    wbyte_q    <= wbyte_d;
    off_low_q  <= off_low_d;
    off_big_q  <= off_big_d;
    wslot_q    <= wslot_d;
    rd_q       <= rd_d;
    rv_q       <= rv_d;
    out_item_q <= out_item_d;
  end

  // --------------------------------------------------------------------------
  // Buffer RAM: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Held bytes never exceed the buffer
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, unread_q} + {1'b0, pending_q}) <= {1'b0, DEPTH_C})
    else $error("held byte count exceeds buffer depth");

  // Unread count tracks the pointer distance
  a_unread_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ap_q - rp_q) == IDX_W'(unread_q))
    else $error("unread count out of step with pointers");

  // The assembled pointer never passes the declared end
  a_end_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_known_q |-> (end_off_q >= unread_q))
    else $error("assembled pointer beyond end index");

  // A returned byte advances the read pointer by one
  a_read_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && rv_d) |=> (rp_q == $past(rp_q) + IDX_W'(1)))
    else $error("read pointer did not advance on read");

endmodule
